// ===== hdl/xmodem_checksum_sender_top_assert.svh =====
// Assertion macros used by the RTL controller.
`ifndef XMODEM_CHECKSUM_SENDER_TOP_ASSERT_SVH
`define XMODEM_CHECKSUM_SENDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define XCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`define XCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define XCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define XCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/xcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xcs_pkg;

	localparam int XCS_BLOCK_BYTES = 128;

	localparam logic [1:0] FN_DATA = 2'd0;
	localparam logic [1:0] FN_EOF  = 2'd1;
	localparam logic [1:0] FN_RX   = 2'd2;
	localparam logic [1:0] FN_SLOT = 2'd3;

	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_EOT = 8'h04;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] value;
	} xcs_in_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       need_data;
		logic       finished;
		logic       cancelled;
		logic [7:0] current_block;
	} xcs_out_t;

endpackage

`default_nettype wire

// ===== hdl/xcs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcs_store
	import xcs_pkg::*;
#(
	parameter int BLOCK_BYTES = XCS_BLOCK_BYTES,
	localparam int AW = $clog2(BLOCK_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [BLOCK_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/xcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "xmodem_checksum_sender_top_assert.svh"

module xcs_ctrl
	import xcs_pkg::*;
#(
	parameter int BLOCK_BYTES = XCS_BLOCK_BYTES,
	localparam int AW = $clog2(BLOCK_BYTES),
	localparam int FW = $clog2(BLOCK_BYTES + 1),
	localparam int IW = $clog2(BLOCK_BYTES + 4)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire xcs_in_t       req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output xcs_out_t           rsp,
	output logic               mem_wr_en,
	output logic      [AW-1:0] mem_wr_addr,
	output logic      [7:0]    mem_wr_data,
	output logic               mem_rd_en,
	output logic      [AW-1:0] mem_rd_addr,
	input  wire logic [7:0]    mem_rd_data
);

	typedef enum logic [2:0] {
		PH_FILL = 3'd0,
		PH_WAIT = 3'd1,
		PH_SEND = 3'd2,
		PH_EOTQ = 3'd3,
		PH_EOTW = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	localparam logic [FW-1:0] FILL_FULL = FW'(BLOCK_BYTES);
	localparam logic [IW-1:0] IDX_SUM   = IW'(BLOCK_BYTES + 3);
	localparam logic [IW-1:0] IDX_DATA  = IW'(3);

	phase_t        phase_q, phase_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    blk_q, blk_d;
	logic          last_q, last_d;
	logic          cancel_q, cancel_d;

	logic          out_valid_q;
	logic          tx_valid_q;
	logic [7:0]    tx_byte_q;
	logic          use_mem_q;
	logic          need_q, fin_q, canc_q;
	logic [7:0]    cur_q;

	logic          accept;
	logic          txv;
	logic [7:0]    txb;
	logic          use_mem;
	logic [IW-1:0] data_idx;
	logic [FW-1:0] fill_inc;

	assign req_ready = !out_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign data_idx  = idx_q - IDX_DATA;
	assign fill_inc  = fill_q + FW'(1);

	always_comb begin
		phase_d  = phase_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		sum_d    = sum_q;
		blk_d    = blk_q;
		last_d   = last_q;
		cancel_d = cancel_q;
		txv      = 1'b0;
		txb      = 8'h00;
		use_mem  = 1'b0;
		mem_wr_en = 1'b0;
		unique case (phase_q)
			PH_FILL: begin
				if (req.func == FN_DATA) begin
					if (fill_q < FILL_FULL) begin
						mem_wr_en = accept;
						fill_d    = fill_inc;
						sum_d     = sum_q + req.value;
					end
					if (fill_d >= FILL_FULL) begin
						last_d  = 1'b0;
						phase_d = PH_WAIT;
					end
				end else if (req.func == FN_EOF) begin
					if (fill_q == '0) begin
						phase_d = PH_EOTQ;
					end else begin
						last_d  = 1'b1;
						phase_d = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (req.func == FN_RX) begin
					if (req.value == CH_CAN) begin
						cancel_d = 1'b1;
						phase_d  = PH_DONE;
					end else if (req.value == CH_ACK) begin
						if (last_q) begin
							phase_d = PH_EOTQ;
						end else begin
							blk_d   = blk_q + 8'd1;
							fill_d  = '0;
							sum_d   = 8'h00;
							phase_d = PH_FILL;
						end
					end else if (req.value == CH_NAK) begin
						idx_d   = '0;
						phase_d = PH_SEND;
					end
				end
			end
			PH_SEND: begin
				if (req.func == FN_SLOT) begin
					txv = 1'b1;
					priority if (idx_q == IW'(0)) begin
						txb = CH_SOH;
					end else if (idx_q == IW'(1)) begin
						txb = blk_q;
					end else if (idx_q == IW'(2)) begin
						txb = ~blk_q;
					end else if (idx_q < IDX_SUM) begin
						use_mem = data_idx < IW'(fill_q);
					end else begin
						txb = sum_q;
					end
					if (idx_q >= IDX_SUM) begin
						idx_d   = '0;
						phase_d = PH_WAIT;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end
			end
			PH_EOTQ: begin
				if (req.func == FN_SLOT) begin
					txv     = 1'b1;
					txb     = CH_EOT;
					phase_d = PH_EOTW;
				end
			end
			PH_EOTW: begin
				if (req.func == FN_RX) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_wr_addr = fill_q[AW-1:0];
	assign mem_wr_data = req.value;
	assign mem_rd_en   = accept && use_mem;
	assign mem_rd_addr = data_idx[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FILL;
			fill_q      <= '0;
			idx_q       <= '0;
			sum_q       <= 8'h00;
			blk_q       <= 8'h01;
			last_q      <= 1'b0;
			cancel_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				fill_q      <= fill_d;
				idx_q       <= idx_d;
				sum_q       <= sum_d;
				blk_q       <= blk_d;
				last_q      <= last_d;
				cancel_q    <= cancel_d;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid_q <= txv;
			tx_byte_q  <= txb;
			use_mem_q  <= use_mem;
			need_q     <= phase_d == PH_FILL;
			fin_q      <= phase_d == PH_DONE;
			canc_q     <= cancel_d;
			cur_q      <= blk_d;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp.tx_valid      = tx_valid_q;
	assign rsp.tx_byte       = use_mem_q ? mem_rd_data : tx_byte_q;
	assign rsp.need_data     = need_q;
	assign rsp.finished      = fin_q;
	assign rsp.cancelled     = canc_q;
	assign rsp.current_block = cur_q;

	`XCS_ASSERT_IMP(a_fill_range, clk, arst_n, 1'b1, fill_q <= FILL_FULL, "fill count overrun")
	`XCS_ASSERT_IMP(a_idx_range, clk, arst_n, phase_q == PH_SEND, idx_q <= IDX_SUM, "send index overrun")
	`XCS_ASSERT_IMP(a_rw_apart, clk, arst_n, mem_rd_en, !mem_wr_en, "read and write in one cycle")
	`XCS_ASSERT_IMP(a_cancel_done, clk, arst_n, rsp_valid && rsp.cancelled, rsp.finished, "cancel not done")
	`XCS_ASSERT_NXT(a_drain, clk, arst_n, rsp_valid && rsp_ready && !accept, !rsp_valid, "stale item")

endmodule

`default_nettype wire

// ===== hdl/xmodem_checksum_sender_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// XMODEM sender, 8-bit checksum, 128-byte blocks. Every item on req gives exactly one
// item on rsp in the next cycle; a new item is taken every cycle as long as rsp is drained,
// since only a single output register sits between the two sides. File bytes are written
// into a block buffer memory as they arrive; while a frame goes out, each data byte is read
// from that memory in the cycle its transmit slot is accepted and appears on rsp from the
// registered read port. No clearing pass is needed after reset: bytes past the end of a
// short block are sent as zero without reading the buffer.
module xmodem_checksum_sender_top
	import xcs_pkg::*;
#(
	parameter int BLOCK_BYTES = XCS_BLOCK_BYTES
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire xcs_in_t req,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	output xcs_out_t     rsp
);

	localparam int AW = $clog2(BLOCK_BYTES);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	xcs_ctrl #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mem_wr_en  (wr_en),
		.mem_wr_addr(wr_addr),
		.mem_wr_data(wr_data),
		.mem_rd_en  (rd_en),
		.mem_rd_addr(rd_addr),
		.mem_rd_data(rd_data)
	);

	xcs_store #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

// ===== tb/xcs_frame_checker.sv =====
`timescale 1ns / 1ps

module xcs_frame_checker
	import xcs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_ready,
	input  wire xcs_in_t  req,
	input  wire logic     rsp_valid,
	input  wire logic     rsp_ready,
	input  wire xcs_out_t rsp,
	output int            outstanding,
	output int            mismatches
);

	typedef enum logic [2:0] {
		PH_FILL,
		PH_WAIT,
		PH_SEND,
		PH_EOT_DUE,
		PH_EOT_SENT,
		PH_DONE
	} sender_phase_e;

	logic [7:0]    block_buf [XCS_BLOCK_BYTES];
	logic [7:0]    held;
	logic [7:0]    frame_pos;
	logic [7:0]    running_sum;
	logic [7:0]    block_num;
	logic          is_last;
	logic          got_can;
	sender_phase_e phase;
	xcs_out_t      status_q [$];
	xcs_out_t      want;
	int            bad_fields;

	function automatic logic [7:0] frame_at(input int pos);
		int d;
		if (pos == 0)
			return CH_SOH;
		if (pos == 1)
			return block_num;
		if (pos == 2)
			return 8'hFF - block_num;
		if (pos < XCS_BLOCK_BYTES + 3) begin
			d = pos - 3;
			return (d < held) ? block_buf[d] : 8'h00;
		end
		return running_sum;
	endfunction

	function automatic xcs_out_t advance(input xcs_in_t it);
		xcs_out_t r;
		r = '0;
		case (phase)
			PH_FILL: begin
				if (it.func == FN_DATA) begin
					if (held < XCS_BLOCK_BYTES) begin
						block_buf[held] = it.value;
						held = held + 8'd1;
						running_sum = running_sum + it.value;
					end
					if (held >= XCS_BLOCK_BYTES) begin
						is_last = 1'b0;
						phase = PH_WAIT;
					end
				end else if (it.func == FN_EOF) begin
					if (held == 8'd0) begin
						phase = PH_EOT_DUE;
					end else begin
						is_last = 1'b1;
						phase = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (it.func == FN_RX) begin
					if (it.value == CH_CAN) begin
						got_can = 1'b1;
						phase = PH_DONE;
					end else if (it.value == CH_ACK) begin
						if (is_last) begin
							phase = PH_EOT_DUE;
						end else begin
							block_num = block_num + 8'd1;
							held = 8'd0;
							running_sum = 8'd0;
							phase = PH_FILL;
						end
					end else if (it.value == CH_NAK) begin
						frame_pos = 8'd0;
						phase = PH_SEND;
					end
				end
			end
			PH_SEND: begin
				if (it.func == FN_SLOT) begin
					r.tx_valid = 1'b1;
					r.tx_byte = frame_at(frame_pos);
					if (frame_pos >= XCS_BLOCK_BYTES + 3) begin
						frame_pos = 8'd0;
						phase = PH_WAIT;
					end else begin
						frame_pos = frame_pos + 8'd1;
					end
				end
			end
			PH_EOT_DUE: begin
				if (it.func == FN_SLOT) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CH_EOT;
					phase = PH_EOT_SENT;
				end
			end
			PH_EOT_SENT: begin
				if (it.func == FN_RX)
					phase = PH_DONE;
			end
			default: ;
		endcase
		r.need_data = (phase == PH_FILL);
		r.finished = (phase == PH_DONE);
		r.cancelled = got_can;
		r.current_block = block_num;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t %s: expected %0h, got %0h", $time, name, exp_v, got_v);
			bad_fields++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 8'd0;
			frame_pos = 8'd0;
			running_sum = 8'd0;
			block_num = 8'd1;
			is_last = 1'b0;
			got_can = 1'b0;
			phase = PH_FILL;
			status_q.delete();
			bad_fields = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (status_q.size() == 0) begin
					$display("%0t item with none expected: expected none, got %0h", $time, rsp);
					bad_fields++;
				end else begin
					want = status_q.pop_front();
					check_field("tx_valid", want.tx_valid, rsp.tx_valid);
					check_field("tx_byte", want.tx_byte, rsp.tx_byte);
					check_field("need_data", want.need_data, rsp.need_data);
					check_field("finished", want.finished, rsp.finished);
					check_field("cancelled", want.cancelled, rsp.cancelled);
					check_field("current_block", want.current_block, rsp.current_block);
				end
			end
			if (req_valid && req_ready)
				status_q.push_back(advance(req));
			outstanding <= status_q.size();
			mismatches <= bad_fields;
		end
	end

endmodule

// ===== tb/xmodem_checksum_sender_top_tb.sv =====
`timescale 1ns / 1ps

module xmodem_checksum_sender_top_tb;
	import xcs_pkg::*;

	localparam int USEFUL_TARGET = 1200;
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_WAIT      = 10;
	localparam int FRAME_BYTES   = XCS_BLOCK_BYTES + 4;

	typedef enum {
		NZ_FILL,
		NZ_WAIT,
		NZ_TX,
		NZ_EOT_SENT,
		NZ_DONE
	} noise_ctx_e;

	typedef enum {
		END_SHORT,
		END_EMPTY,
		END_CANCEL
	} ending_e;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	xcs_in_t  req;
	logic     rsp_valid;
	logic     rsp_ready;
	xcs_out_t rsp;
	int       outstanding;
	int       mismatches;
	int       idle_cycles;
	int       useful_items;
	int       tx_quiet;
	int       rx_quiet;

	xmodem_checksum_sender_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	xcs_frame_checker frame_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] ctl_byte();
		case ($urandom_range(0, 3))
			0: return CH_ACK;
			1: return CH_NAK;
			2: return CH_CAN;
			default: return CH_EOT;
		endcase
	endfunction

	task automatic push_item(input logic [1:0] f, input logic [7:0] v, input bit counted);
		int gap;
		xcs_in_t it;
		if (tx_quiet > 0) begin
			gap = 0;
			tx_quiet--;
		end else begin
			gap = $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 40) == 0)
				tx_quiet = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.func = f;
		it.value = v;
		req_valid <= 1'b1;
		req <= it;
		@(negedge clk);
		while (!req_ready) @(negedge clk);
		@(posedge clk);
		if (counted)
			useful_items++;
	endtask

	task automatic hold_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic sprinkle(input noise_ctx_e ctx, input int odds);
		int n;
		logic [1:0] f;
		logic [7:0] v;
		n = ($urandom_range(0, odds - 1) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			v = ($urandom_range(0, 2) == 0) ? ctl_byte() : 8'($urandom_range(0, 255));
			case (ctx)
				NZ_FILL: f = $urandom_range(0, 1) ? FN_RX : FN_SLOT;
				NZ_WAIT: begin
					f = 2'($urandom_range(0, 3));
					while (f == FN_RX && (v == CH_ACK || v == CH_NAK || v == CH_CAN))
						v = 8'($urandom_range(0, 255));
				end
				NZ_TX: begin
					case ($urandom_range(0, 2))
						0: f = FN_DATA;
						1: f = FN_EOF;
						default: f = FN_RX;
					endcase
				end
				NZ_EOT_SENT: begin
					case ($urandom_range(0, 2))
						0: f = FN_DATA;
						1: f = FN_EOF;
						default: f = FN_SLOT;
					endcase
				end
				default: f = 2'($urandom_range(0, 3));
			endcase
			push_item(f, v, 1'b0);
		end
	endtask

	task automatic fill_bytes(input int n);
		logic [7:0] v;
		repeat (n) begin
			sprinkle(NZ_FILL, 8);
			v = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			push_item(FN_DATA, v, 1'b1);
		end
	endtask

	task automatic send_frame();
		push_item(FN_RX, CH_NAK, 1'b1);
		repeat (FRAME_BYTES) begin
			sprinkle(NZ_TX, 10);
			push_item(FN_SLOT, 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic answer_block();
		sprinkle(NZ_WAIT, 4);
		if ($urandom_range(0, 7) != 0) begin
			send_frame();
			while ($urandom_range(0, 3) == 0) begin
				sprinkle(NZ_WAIT, 4);
				send_frame();
			end
		end
		sprinkle(NZ_WAIT, 4);
	endtask

	task automatic eot_tail();
		sprinkle(NZ_TX, 2);
		push_item(FN_SLOT, 8'($urandom_range(0, 255)), 1'b1);
		sprinkle(NZ_EOT_SENT, 2);
		push_item(FN_RX, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_quiet > 0) begin
				stall = 0;
				rx_quiet--;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 40) == 0)
					rx_quiet = $urandom_range(20, 80);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(negedge clk);
			while (!rsp_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		ending_e ending;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		useful_items = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_item(FN_RX, CH_ACK, 1'b0);
		push_item(FN_RX, CH_NAK, 1'b0);
		push_item(FN_RX, CH_CAN, 1'b0);
		push_item(FN_RX, CH_EOT, 1'b0);
		push_item(FN_SLOT, 8'h00, 1'b0);
		push_item(FN_SLOT, 8'hFF, 1'b0);
		push_item(FN_DATA, 8'h00, 1'b1);
		push_item(FN_DATA, 8'hFF, 1'b1);
		push_item(FN_DATA, 8'h01, 1'b1);
		push_item(FN_DATA, 8'h80, 1'b1);
		push_item(FN_DATA, 8'h7F, 1'b1);
		fill_bytes(XCS_BLOCK_BYTES - 5);
		answer_block();
		hold_for_results();
		push_item(FN_RX, CH_ACK, 1'b1);

		while (useful_items < USEFUL_TARGET) begin
			fill_bytes(XCS_BLOCK_BYTES);
			answer_block();
			push_item(FN_RX, CH_ACK, 1'b1);
		end

		ending = ending_e'($urandom_range(0, 2));
		case (ending)
			END_SHORT: begin
				fill_bytes($urandom_range(1, XCS_BLOCK_BYTES - 1));
				sprinkle(NZ_FILL, 2);
				push_item(FN_EOF, 8'($urandom_range(0, 255)), 1'b1);
				send_frame();
				sprinkle(NZ_WAIT, 2);
				push_item(FN_RX, CH_ACK, 1'b1);
				eot_tail();
			end
			END_EMPTY: begin
				sprinkle(NZ_FILL, 2);
				push_item(FN_EOF, 8'($urandom_range(0, 255)), 1'b1);
				eot_tail();
			end
			default: begin
				fill_bytes(XCS_BLOCK_BYTES);
				send_frame();
				push_item(FN_RX, CH_CAN, 1'b1);
			end
		endcase
		repeat (8) sprinkle(NZ_DONE, 1);

		hold_for_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
